[src/assert_macros.svh]
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked implication assertion, disabled during reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication assertion, disabled during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

[src/dacc_pkg.sv]
// Package with types, opcodes and constants of the decimal accumulator machine.
`timescale 1ns / 1ps
package dacc_pkg;
    localparam int STORE_WORDS = 100;
    localparam int AW = 7;
    localparam int WW = 15;
    localparam logic signed [WW-1:0] WORD_MAX = 15'sd9999;
    localparam logic signed [WW-1:0] WORD_MIN = -15'sd9999;

    localparam logic [2:0] ST_RUN     = 3'd0;
    localparam logic [2:0] ST_HALT    = 3'd1;
    localparam logic [2:0] ST_OVF     = 3'd2;
    localparam logic [2:0] ST_DIV0    = 3'd3;
    localparam logic [2:0] ST_BADREAD = 3'd4;
    localparam logic [2:0] ST_OFFEND  = 3'd5;

    localparam logic [1:0] FN_LOAD    = 2'd0;
    localparam logic [1:0] FN_EXEC    = 2'd1;
    localparam logic [1:0] FN_PEEK    = 2'd2;
    localparam logic [1:0] FN_RESTART = 2'd3;

    localparam logic [6:0] OP_READ  = 7'd10;
    localparam logic [6:0] OP_WRITE = 7'd11;
    localparam logic [6:0] OP_LOAD  = 7'd20;
    localparam logic [6:0] OP_STORE = 7'd21;
    localparam logic [6:0] OP_ADD   = 7'd30;
    localparam logic [6:0] OP_SUB   = 7'd31;
    localparam logic [6:0] OP_DIV   = 7'd32;
    localparam logic [6:0] OP_MUL   = 7'd33;
    localparam logic [6:0] OP_BR    = 7'd40;
    localparam logic [6:0] OP_BRNEG = 7'd41;
    localparam logic [6:0] OP_BRZERO = 7'd42;
    localparam logic [6:0] OP_HALT  = 7'd43;

    // Request to the shared multiply/divide unit.
    typedef struct packed {
        logic                 start;
        logic                 is_div;
        logic signed [WW-1:0] a;
        logic signed [WW-1:0] b;
    } md_req_t;

    typedef struct packed {
        logic                 done;
        logic signed [31:0]   result;
    } md_rsp_t;
endpackage

[src/decimal_accumulator_cpu.sv]
// Top level of the decimal accumulator machine with a 100-word store.
//  channel | dir | handshake         | payload
//  s_axis  | in  | tvalid/tready     | tdata: address, data_word; tuser: func
//  m_axis  | out | tvalid/tready     | tdata: result fields
// From acceptance to a valid result, load and restart go through the peek and
// output states, peek adds fetch, an instruction adds fetch, operand and execute,
// and multiply or divide also use the shared bit-serial unit for 14 steps.
// After reset a clearing pass writes zero to all 100 words, and no item is
// accepted meanwhile.
// A result waits in the output register; the block is ready again in the cycle
// after it has been taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module decimal_accumulator_cpu
    import dacc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // address[6:0], data_word[21:7], zero pad
    input  logic [1:0]  s_axis_tuser,  // func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata   // status, stopped, out_valid, out_word,
                                       // input_taken, program_counter,
                                       // accumulator_value, zero pad
);
    typedef enum logic [7:0] {
        S_CLEAR = 8'b00000001,
        S_IDLE  = 8'b00000010,
        S_FETCH = 8'b00000100,
        S_OPER  = 8'b00001000,
        S_EXEC  = 8'b00010000,
        S_MD    = 8'b00100000,
        S_PEEK  = 8'b01000000,
        S_OUT   = 8'b10000000
    } state_t;

    state_t state_reg, state_next;
    logic signed [WW-1:0] mem [STORE_WORDS];
    logic signed [WW-1:0] rd_reg;
    logic [AW-1:0] raddr;
    logic          we;
    logic [AW-1:0] waddr;
    logic signed [WW-1:0] wdata;

    logic [AW-1:0] clr_reg, clr_next;
    logic [1:0]    func_reg, func_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic signed [WW-1:0] dw_reg, dw_next;
    logic signed [WW-1:0] acc_reg, acc_next;
    logic [AW-1:0] pc_reg, pc_next;
    logic [2:0]    st_reg, st_next;
    logic [6:0]    op_reg, op_next;
    logic [AW-1:0] opd_reg, opd_next;
    logic          ov_reg, ov_next;
    logic signed [WW-1:0] ow_reg, ow_next;
    logic          tk_reg, tk_next;
    logic          mv_reg, mv_next;

    md_req_t md_req;
    md_rsp_t md_rsp;

    logic [1:0]  in_func;
    logic [AW-1:0] in_addr;
    logic signed [WW-1:0] in_dw;
    logic        addr_ok, opd_ok;
    logic signed [WW-1:0] m_val;
    logic signed [WW-1:0] sat_dw;
    logic [WW-1:0] ir_mag;
    logic [13:0] q100;
    logic [6:0]  r100, opc, opd_calc;
    logic signed [WW:0] sum;
    logic [AW:0] pc_inc;

    assign in_func = s_axis_tuser;
    assign in_addr = s_axis_tdata[6:0];
    assign in_dw   = s_axis_tdata[21:7];
    assign addr_ok = addr_reg < AW'(STORE_WORDS);
    assign opd_ok  = opd_reg < AW'(STORE_WORDS);
    assign m_val   = opd_ok ? rd_reg : '0;
    assign sat_dw  = (dw_reg > WORD_MAX) ? WORD_MAX : (dw_reg < WORD_MIN) ? WORD_MIN : dw_reg;

    // Split the fetched word into opcode and operand by reciprocal multiply
    // (magnitude / 100 via *655 >> 16, which is low by at most one, with one
    // correction step).
    always_comb
    begin
        logic [29:0] prod;
        logic [13:0] qe;
        logic [14:0] re;
        ir_mag = rd_reg[WW-1] ? WW'(-rd_reg) : rd_reg;
        prod = 30'(ir_mag) * 30'd655;
        qe = prod[29:16];
        re = ir_mag - 15'(qe * 14'd100);
        if (re >= 15'd100)
        begin
            q100 = qe + 14'd1;
            r100 = 7'(re - 15'd100);
        end
        else
        begin
            q100 = qe;
            r100 = re[6:0];
        end
        // Negative words never yield a valid opcode; operand is then unused.
        opc = rd_reg[WW-1] ? 7'd0 : q100[6:0];
        opd_calc = r100;
    end

    assign sum = (op_reg == OP_SUB) ? (WW+1)'(acc_reg) - (WW+1)'(m_val)
                                    : (WW+1)'(acc_reg) + (WW+1)'(m_val);
    assign pc_inc = {1'b0, pc_reg} + 8'd1;

    // Store, read and written in one clocked block.
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rd_reg <= mem[raddr];
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next = clr_reg;
        func_next = func_reg;
        addr_next = addr_reg;
        dw_next = dw_reg;
        acc_next = acc_reg;
        pc_next = pc_reg;
        st_next = st_reg;
        op_next = op_reg;
        opd_next = opd_reg;
        ov_next = ov_reg;
        ow_next = ow_reg;
        tk_next = tk_reg;
        mv_next = mv_reg;
        we = 1'b0;
        waddr = addr_reg;
        wdata = sat_dw;
        raddr = addr_reg;
        md_req.start = 1'b0;
        md_req.is_div = (op_reg == OP_DIV);
        md_req.a = acc_reg;
        md_req.b = m_val;
        unique case (state_reg)
            S_CLEAR:
            begin
                we = 1'b1;
                waddr = clr_reg;
                wdata = '0;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(STORE_WORDS - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    func_next = in_func;
                    addr_next = in_addr;
                    dw_next = in_dw;
                    ov_next = 1'b0;
                    ow_next = '0;
                    tk_next = 1'b0;
                    state_next = S_PEEK;
                end
            end
            S_PEEK:
            begin
                unique case (func_reg)
                    FN_LOAD:
                    begin
                        we = addr_ok;
                        state_next = S_OUT;
                    end
                    FN_EXEC:
                    begin
                        raddr = pc_reg;
                        if (st_reg != ST_RUN)
                            state_next = S_OUT;
                        else if (pc_reg >= AW'(STORE_WORDS))
                        begin
                            st_next = ST_OFFEND;
                            state_next = S_OUT;
                        end
                        else
                            state_next = S_FETCH;
                    end
                    FN_PEEK:
                    begin
                        // rd_reg is valid next cycle.
                        opd_next = addr_reg;
                        state_next = S_FETCH;
                    end
                    FN_RESTART:
                    begin
                        acc_next = '0;
                        pc_next = '0;
                        st_next = ST_RUN;
                        state_next = S_OUT;
                    end
                    default: state_next = S_OUT;
                endcase
            end
            S_FETCH:
            begin
                if (func_reg == FN_PEEK)
                begin
                    ov_next = 1'b1;
                    ow_next = m_val;
                    state_next = S_OUT;
                end
                else
                begin
                    op_next = opc;
                    opd_next = opd_calc;
                    pc_next = AW'(pc_inc);
                    state_next = S_OPER;
                end
            end
            S_OPER:
            begin
                raddr = opd_reg;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                waddr = opd_reg;
                state_next = S_OUT;
                unique case (op_reg)
                    OP_READ:
                    begin
                        tk_next = 1'b1;
                        if (dw_reg > WORD_MAX || dw_reg < WORD_MIN)
                            st_next = ST_BADREAD;
                        else
                        begin
                            we = opd_ok;
                            wdata = dw_reg;
                        end
                    end
                    OP_WRITE:
                    begin
                        ov_next = 1'b1;
                        ow_next = m_val;
                    end
                    OP_LOAD: acc_next = m_val;
                    OP_STORE:
                    begin
                        we = opd_ok;
                        wdata = acc_reg;
                    end
                    OP_ADD, OP_SUB:
                    begin
                        if (sum > (WW+1)'(WORD_MAX) || sum < (WW+1)'(WORD_MIN))
                            st_next = ST_OVF;
                        else
                            acc_next = WW'(sum);
                    end
                    OP_DIV:
                    begin
                        if (m_val == '0)
                            st_next = ST_DIV0;
                        else
                        begin
                            md_req.start = 1'b1;
                            state_next = S_MD;
                        end
                    end
                    OP_MUL:
                    begin
                        md_req.start = 1'b1;
                        state_next = S_MD;
                    end
                    OP_BR: pc_next = opd_reg;
                    OP_BRNEG: if (acc_reg[WW-1]) pc_next = opd_reg;
                    OP_BRZERO: if (acc_reg == '0) pc_next = opd_reg;
                    OP_HALT: st_next = ST_HALT;
                    default: ;
                endcase
                if (state_next == S_OUT && st_next == ST_RUN
                    && pc_next >= AW'(STORE_WORDS))
                    st_next = ST_OFFEND;
            end
            S_MD:
            begin
                if (md_rsp.done)
                begin
                    if (md_rsp.result > 32'(WORD_MAX) || md_rsp.result < 32'(WORD_MIN))
                        st_next = ST_OVF;
                    else
                        acc_next = WW'(md_rsp.result);
                    if (st_next == ST_RUN && pc_reg >= AW'(STORE_WORDS))
                        st_next = ST_OFFEND;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                mv_next = 1'b1;
                if (mv_reg && m_axis_tready)
                begin
                    mv_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            acc_reg <= '0;
            pc_reg <= '0;
            st_reg <= ST_RUN;
            mv_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            acc_reg <= acc_next;
            pc_reg <= pc_next;
            st_reg <= st_next;
            mv_reg <= mv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        addr_reg <= addr_next;
        dw_reg <= dw_next;
        op_reg <= op_next;
        opd_reg <= opd_next;
        ov_reg <= ov_next;
        ow_reg <= ow_next;
        tk_reg <= tk_next;
    end

    dacc_muldiv u_md (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .rsp   (md_rsp)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = mv_reg;
    assign m_axis_tdata = {5'd0, acc_reg, pc_reg, tk_reg, ow_reg, ov_reg,
                           (st_reg != ST_RUN), st_reg};

    `ASSERT_IMPL(a_out_in_state, mv_reg, state_reg == S_OUT, "result outside output state")
    `ASSERT_IMPL(a_no_accept_busy, mv_reg, !s_axis_tready, "ready while result pending")
    `ASSERT_NEXT(a_pc_range, state_reg == S_OUT, pc_reg <= AW'(STORE_WORDS),
                 "counter beyond store end")
    `ASSERT_IMPL(a_off_end_stops, mv_reg && pc_reg >= AW'(STORE_WORDS) && func_reg == FN_EXEC,
                 st_reg != ST_RUN, "running past store end")
endmodule

[src/dacc_muldiv.sv]
// Shared iterative shift-add multiplier and restoring divider, one bit per cycle.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dacc_muldiv
    import dacc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  md_req_t req,
    output md_rsp_t rsp
);
    logic        busy_reg, busy_next;
    logic        div_reg, div_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    logic [13:0] mag_reg, mag_next;   // multiplicand or divisor magnitude
    logic [27:0] acc_reg, acc_next;   // product, or remainder:quotient
    logic        done_reg, done_next;
    logic [13:0] abs_a, abs_b;
    logic [14:0] trial;
    logic [27:0] shifted;
    logic signed [31:0] mag_res;

    assign abs_a = req.a[WW-1] ? 14'(-req.a) : req.a[13:0];
    assign abs_b = req.b[WW-1] ? 14'(-req.b) : req.b[13:0];
    assign shifted = {acc_reg[26:0], 1'b0};
    // The shifted partial remainder needs 15 bits, so the bit shifted out is kept.
    assign trial = {acc_reg[27], shifted[27:14]} - {1'b0, mag_reg};

    always_comb
    begin
        busy_next = busy_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        mag_next  = mag_reg;
        acc_next  = acc_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            busy_next = 1'b1;
            div_next  = req.is_div;
            cnt_next  = 4'd13;
            neg_next  = req.a[WW-1] ^ req.b[WW-1];
            mag_next  = abs_b;
            acc_next  = req.is_div ? {14'd0, abs_a} : {abs_a, 14'd0};
        end
        else if (busy_reg)
        begin
            if (div_reg)
            begin
                if (!trial[14])
                    acc_next = {trial[13:0], shifted[13:1], 1'b1};
                else
                    acc_next = shifted;
            end
            else
            begin
                // Multiplier bits are consumed from the top of acc.
                acc_next = acc_reg[27] ? shifted + {14'd0, mag_reg} : shifted;
            end
            if (cnt_reg == 4'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
                cnt_next = cnt_reg - 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg  <= div_next;
        cnt_reg  <= cnt_next;
        neg_reg  <= neg_next;
        mag_reg  <= mag_next;
        acc_reg  <= acc_next;
    end

    assign mag_res = div_reg ? $signed({18'd0, acc_reg[13:0]}) : $signed({4'd0, acc_reg});
    assign rsp.done = done_reg;
    assign rsp.result = neg_reg ? -mag_res : mag_res;

    `ASSERT_NEXT(a_done_after_busy, done_reg, !busy_reg, "done while still busy")
    `ASSERT_IMPL(a_no_start_busy, req.start, !busy_reg, "start while busy")
endmodule
